>>> rtl/pal_pkg.sv
// Shared types and constants for the positional array list block.
package pal_pkg;

	// Default array depth and reset value of the capacity register
	localparam int DEPTH_DEF = 16;
	localparam logic [4:0] CAP_RESET = 5'd16;

	// Fixed field widths
	localparam int CMD_W   = 2;
	localparam int POS_W   = 5;
	localparam int VAL_W   = 32;
	localparam int MOVED_W = 4;
	localparam int COUNT_W = 5;
	localparam int CAP_W   = 5;

	// Operation codes
	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	// One result item, handed from the sequencer to the output register
	typedef struct packed {
		logic               status;
		logic [VAL_W-1:0]   data;
		logic [MOVED_W-1:0] moved;
		logic [COUNT_W-1:0] count;
	} result_t;

endpackage

>>> rtl/pal_ram.sv
// Generic single write port, single read port RAM with registered read.
module pal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/pal_ctrl.sv
// Sequencer: range checks, element shifting through the RAM, result build.
module pal_ctrl
	import pal_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int LW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	// request from the input side
	input  logic             start,
	input  cmd_t             cmd,
	input  logic [POS_W-1:0] pos,
	input  logic [VAL_W-1:0] val,
	input  logic [CAP_W-1:0] capacity,
	output logic             ready,
	// result toward the output register
	output logic             res_valid,
	input  logic             res_take,
	output result_t          res,
	// RAM ports
	output logic             ram_we,
	output logic [AW-1:0]    ram_waddr,
	output logic [VAL_W-1:0] ram_wdata,
	output logic [AW-1:0]    ram_raddr,
	input  logic [VAL_W-1:0] ram_rdata
);

	localparam int CW = (LW > POS_W) ? LW : POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_PUT,
		S_DEL,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [LW-1:0]    len_q;
	logic [LW-1:0]    rem_q;
	logic [AW-1:0]    ptr_q;
	logic [AW-1:0]    src_q;
	logic [AW-1:0]    pos_q;
	logic             rd_vld_q;
	logic [VAL_W-1:0] val_q;
	result_t          res_q;

	logic [CW-1:0] pos_w;
	logic [CW-1:0] len_w;
	logic [CW-1:0] cap_w;
	logic [CW-1:0] dep_w;
	logic [CW-1:0] effcap;
	logic          ins_ok;
	logic          rng_ok;
	logic [LW-1:0] pos_l;

	// Range checks against the current length and effective capacity
	always_comb begin
		pos_w  = CW'(pos);
		len_w  = CW'(len_q);
		cap_w  = CW'(capacity);
		dep_w  = CW'(DEPTH);
		effcap = (cap_w > dep_w) ? dep_w : cap_w;
		ins_ok = (len_w < effcap) && (pos_w <= len_w);
		rng_ok = (pos_w < len_w);
		pos_l  = LW'(pos_w);
	end

	// RAM access: reads walk ptr_q, each shift write lands in the cycle after its read
	always_comb begin
		ram_raddr = ptr_q;
		ram_we    = 1'b0;
		ram_waddr = src_q;
		ram_wdata = ram_rdata;
		unique case (state_q)
			S_INS: begin
				ram_we    = rd_vld_q;
				ram_waddr = src_q + AW'(1);
			end
			S_DEL: begin
				ram_we    = rd_vld_q && (src_q != pos_q);
				ram_waddr = src_q - AW'(1);
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = val_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign ready     = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	// Sequencer state and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			len_q    <= '0;
			rem_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					rd_vld_q <= 1'b0;
					if (start) begin
						pos_q        <= AW'(pos_w);
						val_q        <= val;
						res_q.status <= 1'b1;
						res_q.data   <= '0;
						res_q.moved  <= '0;
						res_q.count  <= COUNT_W'(len_q);
						state_q      <= S_DONE;
						priority case (cmd)
							CMD_INSERT: begin
								if (ins_ok) begin
									ptr_q        <= AW'(len_q - LW'(1));
									rem_q        <= len_q - pos_l;
									res_q.status <= 1'b0;
									res_q.moved  <= MOVED_W'(len_q - pos_l);
									res_q.count  <= COUNT_W'(len_q + LW'(1));
									len_q        <= len_q + LW'(1);
									state_q      <= S_INS;
								end
							end
							CMD_DELETE: begin
								if (rng_ok) begin
									ptr_q        <= AW'(pos_w);
									rem_q        <= len_q - pos_l;
									res_q.status <= 1'b0;
									res_q.moved  <= MOVED_W'(len_q - pos_l - LW'(1));
									res_q.count  <= COUNT_W'(len_q - LW'(1));
									len_q        <= len_q - LW'(1);
									state_q      <= S_DEL;
								end
							end
							CMD_READ: begin
								if (rng_ok) begin
									ptr_q        <= AW'(pos_w);
									rem_q        <= LW'(1);
									res_q.status <= 1'b0;
									state_q      <= S_DEL;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				// shift up: read from the top down, write one place higher
				S_INS: begin
					if (rem_q != '0) begin
						src_q    <= ptr_q;
						ptr_q    <= ptr_q - AW'(1);
						rem_q    <= rem_q - LW'(1);
						rd_vld_q <= 1'b1;
					end else begin
						rd_vld_q <= 1'b0;
						state_q  <= S_PUT;
					end
				end
				S_PUT: begin
					state_q <= S_DONE;
				end
				// first read is the target element, later ones shift down
				S_DEL: begin
					if (rd_vld_q && (src_q == pos_q)) begin
						res_q.data <= ram_rdata;
					end
					if (rem_q != '0) begin
						src_q    <= ptr_q;
						ptr_q    <= ptr_q + AW'(1);
						rem_q    <= rem_q - LW'(1);
						rd_vld_q <= 1'b1;
					end else begin
						rd_vld_q <= 1'b0;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/positional_array_list.sv
// Top level of the positional array list: stream ports, capacity register, output register.
//
// A bounded ordered list of DEPTH 32-bit elements kept in a single-port-write RAM.
// Each request inserts, deletes or reads at a zero-based position and yields one
// result with a status, the removed or read value, the number of elements moved
// and the new count. Elements are shifted one per cycle through the RAM's one read
// and one write port. s_tready stays low from the moment a request is accepted
// until its result reaches the output register. The capacity register
// (reset 16, values above DEPTH act as DEPTH) may be written whenever the block
// is idle.
module positional_array_list
	import pal_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // position[4:0], value[36:5], zero fill
	input  logic [1:0]  s_tuser,  // command[1:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // data[31:0], moved[35:32], count[40:36], zero fill
	output logic [0:0]  m_tuser,  // status[0]
	// capacity register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data  // capacity[4:0]
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CAP_W-1:0] cap_q;
	logic             out_valid_q;
	result_t          out_res_q;

	logic             ctrl_ready;
	logic             res_valid;
	logic             res_take;
	result_t          res;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [VAL_W-1:0] ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [VAL_W-1:0] ram_rdata;

	// Capacity register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	assign s_tready = ctrl_ready;

	pal_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_tvalid && s_tready),
		.cmd      (cmd_t'(s_tuser)),
		.pos      (s_tdata[4:0]),
		.val      (s_tdata[36:5]),
		.capacity (cap_q),
		.ready    (ctrl_ready),
		.res_valid(res_valid),
		.res_take (res_take),
		.res      (res),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	pal_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Output register: loads when empty or being drained
	assign res_take = res_valid && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_res_q.count, out_res_q.moved, out_res_q.data};
	assign m_tuser  = out_res_q.status;

endmodule

>>> bench/tb_positional_array_list.sv
`timescale 1ns / 1ps
// Self-checking bench for positional_array_list: directed table, then random traffic of all commands.
module tb_positional_array_list;
	import pal_pkg::*;

	localparam int LIST_DEPTH = DEPTH_DEF;
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam logic ST_DONE   = 1'b0;
	localparam logic ST_REJECT = 1'b1;
	localparam int MAX_GAP     = 18;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE_CYC  = LIST_DEPTH + 8;
	localparam int N_PHASES    = 10;
	localparam int PHASE_ITEMS = 110;
	localparam int N_ROWS      = 22;

	// One line of the directed table; is_cfg rows write capacity from val
	typedef struct packed {
		logic        is_cfg;
		logic [1:0]  cmd;
		logic [4:0]  pos;
		logic [31:0] val;
		logic        typed;
		result_t     res;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;  // position[4:0], value[36:5], zero fill
	logic [1:0]  s_tuser;  // command[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;  // data[31:0], moved[35:32], count[40:36], zero fill
	logic [0:0]  m_tuser;  // status[0]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  cfg_data;

	// Mirror of the list contents and capacity
	logic [31:0] list_mem [LIST_DEPTH];
	int          list_len;
	logic [4:0]  cap_reg;

	result_t     pending_results [$];
	int          errors;
	bit          sender_burst;
	bit          rcv_burst;
	bit          long_hold_req;
	dir_row_t    dir_rows [N_ROWS];
	int          phase_cap [N_PHASES] = '{16, 31, 5, 0, 16, 1, 17, 0, 16, 2};

	positional_array_list u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Apply one request to the mirror and return the result it should produce
	function automatic result_t apply_list_op(logic [1:0] cmd, logic [4:0] pos,
			logic [31:0] val);
		result_t r;
		int      eff_cap;
		int      pos_i;
		int      i;
		r.status = ST_REJECT;
		r.data   = '0;
		r.moved  = '0;
		pos_i    = int'(pos);
		eff_cap  = (int'(cap_reg) > LIST_DEPTH) ? LIST_DEPTH : int'(cap_reg);
		case (cmd)
			CMD_INSERT: begin
				if (list_len < eff_cap && pos_i <= list_len) begin
					for (i = list_len; i > pos_i; i--) begin
						list_mem[i] = list_mem[i-1];
						r.moved = r.moved + 4'd1;
					end
					list_mem[pos_i] = val;
					list_len = list_len + 1;
					r.status = ST_DONE;
				end
			end
			CMD_DELETE: begin
				if (pos_i < list_len) begin
					r.data = list_mem[pos_i];
					for (i = pos_i; i + 1 < list_len; i++) begin
						list_mem[i] = list_mem[i+1];
						r.moved = r.moved + 4'd1;
					end
					list_len = list_len - 1;
					r.status = ST_DONE;
				end
			end
			CMD_READ: begin
				if (pos_i < list_len) begin
					r.data   = list_mem[pos_i];
					r.status = ST_DONE;
				end
			end
			default: ;
		endcase
		r.count = list_len[4:0];
		return r;
	endfunction

	// Offer one request after a random gap (none in bursts); predict it when accepted
	task automatic send_request(logic [1:0] cmd, logic [4:0] pos, logic [31:0] val,
			bit typed, result_t typed_res);
		int      gap;
		result_t r;
		gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = cmd;
		s_tdata  = {3'b000, val, pos};
		do @(posedge clk); while (!s_tready);
		r = apply_list_op(cmd, pos, val);
		pending_results.push_back(typed ? typed_res : r);
		@(negedge clk);
	endtask

	// Stop offering, wait for every result, then let the block settle
	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	// Capacity write, only once the block is idle
	task automatic write_capacity(logic [4:0] cap);
		wait_drained();
		cfg_valid = 1'b1;
		cfg_data  = cap;
		do @(posedge clk); while (!cfg_ready);
		cap_reg = cap;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		$display("%0t ns: %s mismatch, expected 0x%08h, got 0x%08h", $time, name,
			exp_v, got_v);
	endtask

	// Result side: random stalls, a long hold on request, field-by-field check
	initial begin : result_side
		int      stall;
		result_t got;
		result_t want;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_tready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				stall = rcv_burst ? 0 : $urandom_range(0, MAX_GAP);
				if (stall > 0) begin
					m_tready = 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got.status = m_tuser[0];
			got.data   = m_tdata[31:0];
			got.moved  = m_tdata[35:32];
			got.count  = m_tdata[40:36];
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected result, got status %0b data 0x%08h",
					$time, got.status, got.data);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					errors++;
					if (got.status !== want.status)
						report_field("status", 32'(want.status), 32'(got.status));
					if (got.data !== want.data)
						report_field("data", want.data, got.data);
					if (got.moved !== want.moved)
						report_field("moved", 32'(want.moved), 32'(got.moved));
					if (got.count !== want.count)
						report_field("count", 32'(want.count), 32'(got.count));
				end
			end
		end
	end

	// Stimulus
	initial begin : request_side
		int          p;
		int          n;
		int          r;
		int          ins_pct;
		logic [1:0]  cmd;
		logic [4:0]  pos;
		logic [4:0]  cap;
		result_t     no_res;

		no_res = '0;
		// directed table: empty list, extremes, full and zero capacity, unknown command
		dir_rows = '{
			'{1'b0, CMD_READ,    5'd0,  32'h0000_0000, 1'b1, '{ST_REJECT, 32'd0, 4'd0, 5'd0}},
			'{1'b0, CMD_DELETE,  5'd0,  32'h0000_0000, 1'b1, '{ST_REJECT, 32'd0, 4'd0, 5'd0}},
			'{1'b0, CMD_INSERT,  5'd1,  32'h1234_5678, 1'b1, '{ST_REJECT, 32'd0, 4'd0, 5'd0}},
			'{1'b0, CMD_INSERT,  5'd0,  32'h7FFF_FFFF, 1'b1, '{ST_DONE,   32'd0, 4'd0, 5'd1}},
			'{1'b0, CMD_INSERT,  5'd0,  32'h8000_0000, 1'b1, '{ST_DONE,   32'd0, 4'd1, 5'd2}},
			'{1'b0, CMD_READ,    5'd0,  32'h0000_0000, 1'b0, '0},
			'{1'b0, CMD_READ,    5'd31, 32'hFFFF_FFFF, 1'b1, '{ST_REJECT, 32'd0, 4'd0, 5'd2}},
			'{1'b0, CMD_UNKNOWN, 5'd0,  32'hFFFF_FFFF, 1'b1, '{ST_REJECT, 32'd0, 4'd0, 5'd2}},
			'{1'b0, CMD_INSERT,  5'd2,  32'hFFFF_FFFF, 1'b0, '0},
			'{1'b0, CMD_INSERT,  5'd3,  32'h0000_0000, 1'b0, '0},
			'{1'b0, CMD_DELETE,  5'd0,  32'h0000_0000, 1'b0, '0},
			'{1'b0, CMD_DELETE,  5'd31, 32'h0000_0000, 1'b1, '{ST_REJECT, 32'd0, 4'd0, 5'd3}},
			'{1'b0, CMD_READ,    5'd2,  32'h0000_0000, 1'b0, '0},
			'{1'b1, CMD_INSERT,  5'd0,  32'd3,         1'b0, '0},
			'{1'b0, CMD_INSERT,  5'd0,  32'hDEAD_BEEF, 1'b1, '{ST_REJECT, 32'd0, 4'd0, 5'd3}},
			'{1'b1, CMD_INSERT,  5'd0,  32'd0,         1'b0, '0},
			'{1'b0, CMD_INSERT,  5'd0,  32'hDEAD_BEEF, 1'b1, '{ST_REJECT, 32'd0, 4'd0, 5'd3}},
			'{1'b0, CMD_DELETE,  5'd2,  32'h0000_0000, 1'b0, '0},
			'{1'b1, CMD_INSERT,  5'd0,  32'd31,        1'b0, '0},
			'{1'b0, CMD_INSERT,  5'd2,  32'h5555_5555, 1'b0, '0},
			'{1'b0, CMD_INSERT,  5'd1,  32'hAAAA_AAAA, 1'b0, '0},
			'{1'b0, CMD_READ,    5'd16, 32'h0000_0000, 1'b1, '{ST_REJECT, 32'd0, 4'd0, 5'd4}}
		};

		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		errors        = 0;
		sender_burst  = 1'b0;
		rcv_burst     = 1'b0;
		long_hold_req = 1'b0;
		list_len      = 0;
		cap_reg       = CAP_RESET;
		for (n = 0; n < LIST_DEPTH; n++) list_mem[n] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part
		for (n = 0; n < N_ROWS; n++) begin
			if (dir_rows[n].is_cfg)
				write_capacity(dir_rows[n].val[4:0]);
			else
				send_request(dir_rows[n].cmd, dir_rows[n].pos, dir_rows[n].val,
					dir_rows[n].typed, dir_rows[n].res);
		end

		// random phases, alternating growth and shrink bias
		for (p = 0; p < N_PHASES; p++) begin
			cap = (p == 7) ? 5'($urandom_range(0, 31)) : 5'(phase_cap[p]);
			write_capacity(cap);
			ins_pct      = (p % 2 == 0) ? 70 : 30;
			sender_burst = (p % 5 == 4) || (p == 3);
			rcv_burst    = (p % 5 == 4) || (p == 6);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// fill the block while results are held back
				if (p == 2 && n == 40) long_hold_req = 1'b1;
				// let everything drain mid-phase
				if (p == 5 && n == 55) wait_drained();
				r = $urandom_range(0, 99);
				if (r < ins_pct)
					cmd = CMD_INSERT;
				else if (r < 95)
					cmd = (r % 2) ? CMD_DELETE : CMD_READ;
				else
					cmd = CMD_UNKNOWN;
				if ($urandom_range(0, 4) == 0)
					pos = 5'($urandom_range(0, 31));
				else if (cmd == CMD_INSERT)
					pos = 5'($urandom_range(0, list_len));
				else
					pos = (list_len > 0) ? 5'($urandom_range(0, list_len - 1)) : 5'd0;
				send_request(cmd, pos, $urandom, 1'b0, no_res);
			end
		end

		wait_drained();
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
